[rtl/core/sagt_pkg.sv]
package sagt_pkg;

  typedef logic signed [32:0] q_t;
  typedef logic        [31:0] sq_t;
  typedef logic signed [34:0] ang_t;
  typedef logic signed [16:0] trq_t;
  typedef logic signed [14:0] raw_t;

  localparam int NJ      = 6;
  localparam int SIN_LAT = 29;
  localparam int CF_LAT  = 8;
  localparam int LAT     = 1 + SIN_LAT + CF_LAT;

  localparam ang_t Q30_PI      = 35'sd3373259426;
  localparam ang_t Q30_HALF_PI = 35'sd1686629713;
  localparam ang_t Q30_TWO_PI  = 35'sd6746518852;
  localparam q_t   Q30_ONE     = 33'sd1073741824;

  localparam q_t K_C7A   = 33'sd27568;
  localparam q_t K_S7A   = 33'sd1347;
  localparam q_t K_OFF7  = 33'sd14129;
  localparam q_t K_LINK6 = 33'sd2086598;
  localparam q_t K_OFF6  = 33'sd1806;
  localparam q_t K_OFF5B = 33'sd1226515;
  localparam q_t K_OFF5  = 33'sd17993;
  localparam q_t K_LINK4 = 33'sd38832749;
  localparam q_t K_OFF4  = 33'sd9771;
  localparam q_t K_LINK3 = 33'sd265252;
  localparam q_t K_LINK2 = 33'sd97550811;
  localparam q_t K_OFF2  = 33'sd1773;
  localparam q_t K_GRAV  = 33'sd164584489;

  localparam trq_t TRQ_MAX = 17'sd65535;
  localparam trq_t TRQ_MIN = -TRQ_MAX - 17'sd1;

  // rounding shift, halves away from zero
  function automatic logic signed [65:0] rnd_sh(input logic signed [65:0] v, input int n);
    logic signed [65:0] mag;
    logic signed [65:0] r;
    mag = v[65] ? -v : v;
    r = (mag + (66'sd1 <<< (n - 1))) >>> n;
    return v[65] ? -r : r;
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [65:0] p;
    p = a * b;
    return q_t'(rnd_sh(p, 24));
  endfunction

  function automatic trq_t sat_trq(input q_t v);
    logic signed [65:0] r;
    r = rnd_sh(66'(v), 16);
    if (r > 66'(TRQ_MAX)) begin
      return TRQ_MAX;
    end else if (r < 66'(TRQ_MIN)) begin
      return TRQ_MIN;
    end else begin
      return trq_t'(r);
    end
  endfunction

endpackage

[rtl/core/sagt_hstep.sv]
module sagt_hstep #(
  parameter int K = 1
) (
  input  logic          clk,
  input  sagt_pkg::sq_t x2_i,
  input  sagt_pkg::q_t  t_i,
  input  sagt_pkg::q_t  x_i,
  output sagt_pkg::sq_t x2_o,
  output sagt_pkg::q_t  t_o,
  output sagt_pkg::q_t  x_o
);
  import sagt_pkg::*;

  localparam int          Den   = 2 * K * (2 * K + 1);
  localparam longint      Recip = (longint'(1) << 33) / Den;
  localparam logic [63:0] Half  = 64'(Den) << 29;
  localparam logic [30:0] RecipV = 31'(Recip);
  localparam logic [8:0]  DenV   = 9'(Den);

  logic signed [65:0] prod;
  logic        [63:0] mag;
  logic        [64:0] sum;
  logic        [32:0] b_a;
  logic               neg_a;
  sq_t                x2_a;
  q_t                 x_a;

  logic        [63:0] pm;
  logic        [30:0] q0;
  logic        [32:0] b_b;
  logic               neg_b;
  sq_t                x2_b;
  q_t                 x_b;

  logic        [40:0] qd;
  logic        [40:0] rem;
  logic        [31:0] q;
  q_t                 t_next;

  // stage a: product and rounding offset
  always_comb begin
    prod = $signed({1'b0, x2_i}) * t_i;
    mag  = prod[65] ? 64'(-prod) : 64'(prod);
    sum  = 65'(mag) + 65'(Half);
  end

  always_ff @(posedge clk) begin
    b_a   <= sum[62:30];
    neg_a <= prod[65];
    x2_a  <= x2_i;
    x_a   <= x_i;
  end

  // stage b: reciprocal estimate
  always_comb begin
    pm = 64'(b_a) * 64'(RecipV);
  end

  always_ff @(posedge clk) begin
    q0    <= pm[63:33];
    b_b   <= b_a;
    neg_b <= neg_a;
    x2_b  <= x2_a;
    x_b   <= x_a;
  end

  // stage c: one correction step, then next horner term
  always_comb begin
    qd  = 41'(q0) * 41'(DenV);
    rem = 41'(b_b) - qd;
    q   = (rem >= 41'(DenV)) ? 32'(q0) + 32'd1 : 32'(q0);
    t_next = neg_b ? Q30_ONE + $signed({1'b0, q}) : Q30_ONE - $signed({1'b0, q});
  end

  always_ff @(posedge clk) begin
    t_o  <= t_next;
    x2_o <= x2_b;
    x_o  <= x_b;
  end

endmodule

[rtl/core/sagt_sine.sv]
module sagt_sine (
  input  logic           clk,
  input  sagt_pkg::ang_t ang,
  output sagt_pkg::q_t   sin_q
);
  import sagt_pkg::*;

  ang_t w;
  ang_t wr;
  ang_t f;
  q_t   x0;
  logic signed [65:0] sq;
  logic signed [65:0] sq_r;
  sq_t  x2r;
  q_t   xr;
  sq_t  x2_c [9];
  q_t   t_c  [9];
  q_t   x_c  [9];
  logic signed [65:0] pf;
  q_t   r1;

  // wrap into [-pi, pi]
  always_comb begin
    w = ang;
    if (w > Q30_PI) begin
      w = w - Q30_TWO_PI;
    end
    if (w < -Q30_PI) begin
      w = w + Q30_TWO_PI;
    end
  end

  always_ff @(posedge clk) begin
    wr <= w;
  end

  // fold into [-pi/2, pi/2]
  always_comb begin
    f = wr;
    if (f > Q30_HALF_PI) begin
      f = Q30_PI - f;
    end
    if (f < -Q30_HALF_PI) begin
      f = -Q30_PI - f;
    end
  end

  always_ff @(posedge clk) begin
    x0 <= q_t'(f);
  end

  always_comb begin
    sq   = x0 * x0;
    sq_r = rnd_sh(sq, 30);
  end

  always_ff @(posedge clk) begin
    x2r <= sq_r[31:0];
    xr  <= x0;
  end

  assign x2_c[0] = x2r;
  assign t_c[0]  = Q30_ONE;
  assign x_c[0]  = xr;

  for (genvar i = 0; i < 8; i++) begin : g_step
    sagt_hstep #(.K(8 - i)) u_step (
      .clk  (clk),
      .x2_i (x2_c[i]),
      .t_i  (t_c[i]),
      .x_i  (x_c[i]),
      .x2_o (x2_c[i+1]),
      .t_o  (t_c[i+1]),
      .x_o  (x_c[i+1])
    );
  end

  always_comb begin
    pf = x_c[8] * t_c[8];
  end

  always_ff @(posedge clk) begin
    r1    <= q_t'(rnd_sh(pf, 30));
    sin_q <= q_t'(rnd_sh(66'(r1), 6));
  end

endmodule

[rtl/core/sagt_cform.sv]
module sagt_cform (
  input  logic           clk,
  input  logic           hanging,
  input  sagt_pkg::q_t   sn [6],
  input  sagt_pkg::q_t   cs [6],
  output sagt_pkg::trq_t torque [6]
);
  import sagt_pkg::*;

  localparam int I2 = 0;
  localparam int I3 = 1;
  localparam int I4 = 2;
  localparam int I5 = 3;
  localparam int I6 = 4;
  localparam int I7 = 5;

  q_t sd [5][6];
  q_t cd [5][6];

  q_t p7c, p7s, mc, ms;
  q_t a7, r7, v5, q7, sl6, cl6, k3s3_1, k3c3_1, c5s4_1;

  q_t a6c, a6s;
  q_t b6, e6, l6, dd, r3, vc3, vs5, vc5, r7s6, qc6, qc5, r7s3, r7s5;
  q_t k3s3_2, k3c3_2, c5s4_2;

  q_t u5, e6s4, m5, bs3, bc3, r3c5, r3s5, vc3c5, ddc5, l6s4, dds3, e4, f5;
  q_t r7s6s4, r7s3c5, qc6s3, r7s6c4, h5, z3, k3s3_3, k3c3_3;

  q_t uc4, us4;
  q_t h4, t0b, x2a, y2, bs3s5, bc3s5, bs3c5, zc4, zs4, dd4, dds3s5, e4c2, g5;
  q_t qc6s3s5, j5, r3c5_4, vc3c5_4, k3s3_4, k3c3_4, r3s5_4, r7s3c5_4;

  q_t t0a, t0bs2, t1, x2c3, y2c2, t3, zs4c2, d5, e4c2_5, k5, j5c2;

  q_t acc  [6];
  q_t prod [6];
  q_t grav;

  always_ff @(posedge clk) begin
    sd[0] <= sn;
    cd[0] <= cs;
    for (int d = 1; d < 5; d++) begin
      sd[d] <= sd[d-1];
      cd[d] <= cd[d-1];
    end
  end

  // stage 1
  always_comb begin
    p7c = qmul(K_C7A, cs[I7]);
    p7s = qmul(K_S7A, sn[I7]);
    mc  = qmul(K_S7A, cs[I7]);
    ms  = qmul(K_C7A, sn[I7]);
  end

  always_ff @(posedge clk) begin
    a7     <= K_OFF7 - p7c - p7s;
    r7     <= p7s + p7c;
    v5     <= ms - mc - K_OFF5B;
    q7     <= ms - mc;
    sl6    <= qmul(K_LINK6, sn[I6]);
    cl6    <= qmul(K_LINK6, cs[I6]);
    k3s3_1 <= qmul(K_LINK3, sn[I3]);
    k3c3_1 <= qmul(K_LINK3, cs[I3]);
    c5s4_1 <= qmul(cs[I5], sn[I4]);
  end

  // stage 2
  always_comb begin
    a6c = qmul(a7, cd[0][I6]);
    a6s = qmul(a7, sd[0][I6]);
  end

  always_ff @(posedge clk) begin
    b6     <= a6c - sl6 + K_OFF6;
    e6     <= cl6 + a6s + K_LINK4;
    l6     <= a6c - sl6;
    dd     <= a6s + cl6;
    r3     <= qmul(v5, sd[0][I3]);
    vc3    <= qmul(v5, cd[0][I3]);
    vs5    <= qmul(v5, sd[0][I5]);
    vc5    <= qmul(v5, cd[0][I5]);
    r7s6   <= qmul(q7, sd[0][I6]);
    qc6    <= qmul(q7, cd[0][I6]);
    qc5    <= qmul(q7, cd[0][I5]);
    r7s3   <= qmul(r7, sd[0][I3]);
    r7s5   <= qmul(r7, sd[0][I5]);
    k3s3_2 <= k3s3_1;
    k3c3_2 <= k3c3_1;
    c5s4_2 <= c5s4_1;
  end

  // stage 3
  always_ff @(posedge clk) begin
    u5     <= qmul(b6, cd[1][I5]) + vs5 + K_OFF5;
    e6s4   <= qmul(e6, sd[1][I4]);
    m5     <= qmul(e6, cd[1][I4]);
    bs3    <= qmul(b6, sd[1][I3]);
    bc3    <= qmul(b6, cd[1][I3]);
    r3c5   <= qmul(r3, cd[1][I5]);
    r3s5   <= qmul(r3, sd[1][I5]);
    vc3c5  <= qmul(vc3, cd[1][I5]);
    ddc5   <= qmul(dd, cd[1][I5]);
    l6s4   <= qmul(l6, sd[1][I4]);
    dds3   <= qmul(dd, sd[1][I3]);
    e4     <= qmul(c5s4_2, dd) + qmul(cd[1][I4], l6);
    f5     <= qmul(qc5, cd[1][I6]) + r7s5;
    r7s6s4 <= qmul(r7s6, sd[1][I4]);
    r7s3c5 <= qmul(r7s3, cd[1][I5]);
    qc6s3  <= qmul(qc6, sd[1][I3]);
    r7s6c4 <= qmul(r7s6, cd[1][I4]);
    h5     <= -r7s5 - qmul(qc6, cd[1][I5]);
    z3     <= qmul(b6, sd[1][I5]) - vc5;
    k3s3_3 <= k3s3_2;
    k3c3_3 <= k3c3_2;
  end

  // stage 4
  always_comb begin
    uc4 = qmul(u5, cd[2][I4]);
    us4 = qmul(u5, sd[2][I4]);
  end

  always_ff @(posedge clk) begin
    h4       <= uc4 + e6s4 + K_OFF4;
    t0b      <= m5 - us4 + K_LINK2;
    x2a      <= m5 - us4;
    y2       <= -uc4 - e6s4;
    bs3s5    <= qmul(bs3, sd[2][I5]);
    bc3s5    <= qmul(bc3, sd[2][I5]);
    bs3c5    <= qmul(bs3, cd[2][I5]);
    zc4      <= qmul(z3, cd[2][I4]);
    zs4      <= qmul(z3, sd[2][I4]);
    dd4      <= l6s4 - qmul(ddc5, cd[2][I4]);
    dds3s5   <= qmul(dds3, sd[2][I5]);
    e4c2     <= qmul(e4, cd[2][I2]);
    g5       <= qmul(f5, cd[2][I4]) + r7s6s4;
    qc6s3s5  <= qmul(qc6s3, sd[2][I5]);
    j5       <= r7s6c4 + qmul(h5, sd[2][I4]);
    r3c5_4   <= r3c5;
    vc3c5_4  <= vc3c5;
    k3s3_4   <= k3s3_3;
    k3c3_4   <= k3c3_3;
    r3s5_4   <= r3s5;
    r7s3c5_4 <= r7s3c5;
  end

  // stage 5
  always_ff @(posedge clk) begin
    t0a    <= qmul(h4, cd[3][I3]) + r3c5_4 - bs3s5 - k3s3_4 + K_OFF2;
    t0bs2  <= qmul(t0b, sd[3][I2]);
    t1     <= vc3c5_4 - qmul(h4, sd[3][I3]) - bc3s5 - k3c3_4;
    x2c3   <= qmul(x2a, cd[3][I3]);
    y2c2   <= qmul(y2, cd[3][I2]);
    t3     <= -qmul(zc4, cd[3][I3]) - r3s5_4 - bs3c5;
    zs4c2  <= qmul(zs4, cd[3][I2]);
    d5     <= qmul(dd4, cd[3][I3]) + dds3s5;
    e4c2_5 <= e4c2;
    k5     <= qmul(g5, cd[3][I3]) + r7s3c5_4 - qc6s3s5;
    j5c2   <= qmul(j5, cd[3][I2]);
  end

  // stage 6
  always_ff @(posedge clk) begin
    acc[0] <= qmul(t0a, cd[4][I2]) - t0bs2;
    acc[1] <= qmul(t1, sd[4][I2]);
    acc[2] <= qmul(x2c3, sd[4][I2]) + y2c2;
    acc[3] <= qmul(t3, sd[4][I2]) + zs4c2;
    acc[4] <= qmul(d5, sd[4][I2]) + e4c2_5;
    acc[5] <= qmul(k5, sd[4][I2]) + j5c2;
  end

  // stage 7 and 8: gravity, round and saturate
  assign grav = hanging ? -K_GRAV : K_GRAV;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      prod[i]   <= qmul(grav, acc[i]);
      torque[i] <= sat_trq(prod[i]);
    end
  end

endmodule

[rtl/core/seven_axis_gravity_torque.sv]
// channel   ports                                       handshake
// ------    ------------------------------------------  ----------------------------
// input     angle_joint2 .. angle_joint7               start high, busy low
// result    torque_joint2 .. torque_joint7             done high for one cycle
// config    cfg_wr_data (mounting, 1 = hanging)        cfg_wr_en high
//
// from the accepting edge to the edge that takes the result, an item passes one input
// register, a sine unit (8 horner steps of 3 stages) and the closed form pipeline.
// one item is taken every cycle; busy stays low.
// rst clears the valid chain and the mounting register.
// the receiver cannot stall, so nothing is ever held back.
module seven_axis_gravity_torque (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [14:0]  angle_joint2,
  input  logic signed [14:0]  angle_joint3,
  input  logic signed [14:0]  angle_joint4,
  input  logic signed [14:0]  angle_joint5,
  input  logic signed [14:0]  angle_joint6,
  input  logic signed [14:0]  angle_joint7,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  output logic                done,
  output logic signed [16:0]  torque_joint2,
  output logic signed [16:0]  torque_joint3,
  output logic signed [16:0]  torque_joint4,
  output logic signed [16:0]  torque_joint5,
  output logic signed [16:0]  torque_joint6,
  output logic signed [16:0]  torque_joint7
);
  import sagt_pkg::*;

  logic             hanging;
  logic [LAT-1:0]   vld;
  logic             accept;
  raw_t             raw  [NJ];
  ang_t             base [NJ];
  ang_t             ang_s [NJ];
  ang_t             ang_c [NJ];
  q_t               sn [NJ];
  q_t               cs [NJ];
  trq_t             trq [NJ];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign raw[0] = angle_joint2;
  assign raw[1] = angle_joint3;
  assign raw[2] = angle_joint4;
  assign raw[3] = angle_joint5;
  assign raw[4] = angle_joint6;
  assign raw[5] = angle_joint7;

  always_comb begin
    for (int i = 0; i < NJ; i++) begin
      base[i] = {{2{raw[i][14]}}, raw[i], 18'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hanging <= 1'b0;
    end else if (cfg_wr_en) begin
      hanging <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NJ; i++) begin
        ang_s[i] <= base[i];
        ang_c[i] <= base[i] + Q30_HALF_PI;
      end
    end
  end

  for (genvar i = 0; i < NJ; i++) begin : g_trig
    sagt_sine u_sin (
      .clk   (clk),
      .ang   (ang_s[i]),
      .sin_q (sn[i])
    );
    sagt_sine u_cos (
      .clk   (clk),
      .ang   (ang_c[i]),
      .sin_q (cs[i])
    );
  end

  sagt_cform u_cform (
    .clk     (clk),
    .hanging (hanging),
    .sn      (sn),
    .cs      (cs),
    .torque  (trq)
  );

  assign done          = vld[LAT-1];
  assign torque_joint2 = trq[0];
  assign torque_joint3 = trq[1];
  assign torque_joint4 = trq[2];
  assign torque_joint5 = trq[3];
  assign torque_joint6 = trq[4];
  assign torque_joint7 = trq[5];

endmodule
